### design/mctt_pkg.sv
// mctt_pkg: shared constants and types for the tick timer bank.
// Used by mctt_ctrl, mctt_dp and multi_channel_tick_timer_bank.
`timescale 1ns / 1ps
package mctt_pkg;

  // Bank geometry
  localparam int CHANNELS    = 8;
  localparam int COUNT_WIDTH = 32;

  // Item field widths
  localparam int OP_W    = 2;
  localparam int CH_W    = 3;
  localparam int LIMIT_W = 32;
  localparam int MASK_W  = 8;

  // Width used to compare a channel field against a channel number
  localparam int SEL_W = 6;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic do_tick;   // advance every running channel
    logic do_start;  // arm the addressed channel
    logic do_stop;   // clear the addressed channel
    logic load_out;  // capture the result mask into the output register
  } cmd_t;

endpackage

### design/mctt_ctrl.sv
// mctt_ctrl: handshake controller and operation decoder for the timer bank.
// Depends on mctt_pkg; drives mctt_dp through a cmd_t bundle.
`timescale 1ns / 1ps
module mctt_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mctt_pkg::OP_W-1:0]   operation_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mctt_pkg::cmd_t              cmd_o
);

  // Output register state: empty or holding a result item
  localparam logic S_EMPTY = 1'b0;
  localparam logic S_FULL  = 1'b1;

  logic state_q, state_d;
  logic accept;

  // A new item enters whenever the output slot is free or draining now
  assign in_ready_o  = (state_q == S_EMPTY) || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_FULL);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_EMPTY: if (accept) state_d = S_FULL;
      S_FULL:  if (out_ready_i && !accept) state_d = S_EMPTY;
      default: state_d = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  // Operation decode; unused code only loads a zero mask
  always_comb begin
    cmd_o          = '0;
    cmd_o.load_out = accept;
    case (operation_i)
      mctt_pkg::OP_TICK:  cmd_o.do_tick  = accept;
      mctt_pkg::OP_START: cmd_o.do_start = accept;
      mctt_pkg::OP_STOP:  cmd_o.do_stop  = accept;
      default:            ;
    endcase
  end

  // Assertions
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output slot is empty");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item produced no result");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.do_tick, cmd_o.do_start, cmd_o.do_stop}))
    else $error("more than one operation issued");

endmodule

### design/mctt_dp.sv
// mctt_dp: per-channel timer registers and the expired-mask output register.
// Depends on mctt_pkg; commanded by mctt_ctrl.
`timescale 1ns / 1ps
module mctt_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mctt_pkg::cmd_t                 cmd_i,
  input  logic [mctt_pkg::CH_W-1:0]      channel_i,
  input  logic [mctt_pkg::LIMIT_W-1:0]   limit_i,
  input  logic                           notify_i,
  output logic [mctt_pkg::MASK_W-1:0]    expired_mask_o
);

  localparam int N  = mctt_pkg::CHANNELS;
  localparam int CW = mctt_pkg::COUNT_WIDTH;
  localparam int MW = mctt_pkg::MASK_W;

  logic [N-1:0]  running_q, running_d;
  logic [N-1:0]  expired_q, expired_d;
  logic [N-1:0]  notify_q,  notify_d;
  logic [CW-1:0] count_q [N];
  logic [CW-1:0] count_d [N];
  logic [CW-1:0] limit_q [N];
  logic [N-1:0]  sel;
  logic [N-1:0]  hit;
  logic [MW-1:0] mask_d, mask_q;
  logic [CW-1:0] limit_ext;

  assign limit_ext = CW'(limit_i);

  // Per-channel next state
  for (genvar c = 0; c < N; c++) begin : g_ch
    logic below;
    assign sel[c] = (mctt_pkg::SEL_W'(channel_i) == mctt_pkg::SEL_W'(c));
    assign below  = (count_q[c] < limit_q[c]);

    always_comb begin
      running_d[c] = running_q[c];
      expired_d[c] = expired_q[c];
      notify_d[c]  = notify_q[c];
      count_d[c]   = count_q[c];
      if (cmd_i.do_tick && running_q[c]) begin
        if (below) count_d[c] = count_q[c] + CW'(1);
        else       expired_d[c] = 1'b1;
      end else if (cmd_i.do_start && sel[c]) begin
        running_d[c] = 1'b1;
        expired_d[c] = 1'b0;
        notify_d[c]  = notify_i;
        count_d[c]   = '0;
      end else if (cmd_i.do_stop && sel[c]) begin
        running_d[c] = 1'b0;
        expired_d[c] = 1'b0;
        notify_d[c]  = 1'b0;
        count_d[c]   = '0;
      end
    end

    assign hit[c] = running_q[c] && expired_d[c] && notify_q[c];

    // Count and limit: no reset, written by start before use
    always_ff @(posedge clk_i) begin
      count_q[c] <= count_d[c];
      if (cmd_i.do_start && sel[c]) limit_q[c] <= limit_ext;
    end
  end

  // Flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      expired_q <= '0;
      notify_q  <= '0;
    end else begin
      running_q <= running_d;
      expired_q <= expired_d;
      notify_q  <= notify_d;
    end
  end

  // Result mask: only the low channels are reported, zero unless a tick
  for (genvar b = 0; b < MW; b++) begin : g_mask
    if (b < N) begin : g_on
      assign mask_d[b] = cmd_i.do_tick && hit[b];
    end else begin : g_off
      assign mask_d[b] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) mask_q <= mask_d;
  end

  assign expired_mask_o = mask_q;

  // Assertions
  for (genvar c = 0; c < N; c++) begin : g_chk
    a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
      running_q[c] |-> (count_q[c] <= limit_q[c]))
      else $error("channel count passed its limit");

    a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !running_q[c] |-> (!expired_q[c] && !notify_q[c]))
      else $error("stopped channel holds stale flags");

    a_expired_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (expired_q[c] && !cmd_i.do_start && !cmd_i.do_stop) |=> expired_q[c])
      else $error("expired mark dropped without start or stop");
  end

endmodule

### design/multi_channel_tick_timer_bank.sv
// multi_channel_tick_timer_bank: top level of the tick timer bank.
// Depends on mctt_pkg, mctt_ctrl and mctt_dp.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item: operation_i
//   (tick, start, stop), channel_i, limit_i and notify_i. A start arms one
//   channel with its limit and notify bit; a stop clears it; a tick advances
//   every running channel in parallel.
//   Output channel (out_valid_o / out_ready_i) returns one item per input
//   item: expired_mask_o, set on a tick for channels that are running,
//   expired and notify-enabled, and zero for any other operation.
//   The result is in the output register in the cycle after the item is
//   accepted. Throughput: one item per cycle unless stalled; all channels
//   update in the same cycle from their own count and limit registers.
//   Stall: the output register holds its item while out_ready_i is low, and
//   in_ready_o drops only while that register is full and not being taken.
//   Reset (rst_ni low, asynchronous): all channels stopped, flags cleared,
//   output empty. No clearing pass is needed.
`timescale 1ns / 1ps
module multi_channel_tick_timer_bank (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mctt_pkg::OP_W-1:0]     operation_i,
  input  logic [mctt_pkg::CH_W-1:0]     channel_i,
  input  logic [mctt_pkg::LIMIT_W-1:0]  limit_i,
  input  logic                          notify_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mctt_pkg::MASK_W-1:0]   expired_mask_o
);

  mctt_pkg::cmd_t cmd;

  // Handshake control and decode
  mctt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Timer channels and result register
  mctt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .channel_i      (channel_i),
    .limit_i        (limit_i),
    .notify_i       (notify_i),
    .expired_mask_o (expired_mask_o)
  );

endmodule

### tb/sv/multi_channel_tick_timer_bank_tb.sv
// Self-checking testbench for multi_channel_tick_timer_bank: a scoreboard class
// tracks every timer channel and predicts the expired mask of each item.
// Depends on mctt_pkg and the multi_channel_tick_timer_bank RTL.
`timescale 1ns / 1ps
module multi_channel_tick_timer_bank_tb;

  // Operation code that the block ignores
  localparam logic [mctt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 4;

  // Predicts the mask of each accepted item and checks results in order
  class expiry_tracker;
    bit                             ch_running [mctt_pkg::CHANNELS];
    bit                             ch_expired [mctt_pkg::CHANNELS];
    bit                             ch_notify  [mctt_pkg::CHANNELS];
    bit [mctt_pkg::COUNT_WIDTH-1:0] ch_count   [mctt_pkg::CHANNELS];
    bit [mctt_pkg::COUNT_WIDTH-1:0] ch_limit   [mctt_pkg::CHANNELS];
    logic [mctt_pkg::MASK_W-1:0]    pending_masks [$];
    int                             errors;

    function void record_item(logic [mctt_pkg::OP_W-1:0] op,
                              logic [mctt_pkg::CH_W-1:0] ch,
                              logic [mctt_pkg::LIMIT_W-1:0] lim, logic ntf);
      logic [mctt_pkg::MASK_W-1:0] mask;
      mask = '0;
      case (op)
        mctt_pkg::OP_TICK: begin
          for (int c = 0; c < mctt_pkg::CHANNELS; c++) begin
            if (ch_running[c]) begin
              if (ch_count[c] < ch_limit[c]) ch_count[c] = ch_count[c] + 1'b1;
              else ch_expired[c] = 1'b1;
              if (ch_expired[c] && ch_notify[c] && c < mctt_pkg::MASK_W) mask[c] = 1'b1;
            end
          end
        end
        mctt_pkg::OP_START: begin
          if (int'(ch) < mctt_pkg::CHANNELS) begin
            ch_expired[ch] = 1'b0;
            ch_running[ch] = 1'b1;
            ch_limit[ch]   = mctt_pkg::COUNT_WIDTH'(lim);
            ch_count[ch]   = '0;
            ch_notify[ch]  = ntf;
          end
        end
        mctt_pkg::OP_STOP: begin
          // limit register is kept across a stop
          if (int'(ch) < mctt_pkg::CHANNELS) begin
            ch_running[ch] = 1'b0;
            ch_expired[ch] = 1'b0;
            ch_count[ch]   = '0;
            ch_notify[ch]  = 1'b0;
          end
        end
        default: ;
      endcase
      pending_masks.push_back(mask);
    endfunction

    function void compare_mask(logic [mctt_pkg::MASK_W-1:0] actual);
      logic [mctt_pkg::MASK_W-1:0] want;
      if (pending_masks.size() == 0) begin
        $error("expired_mask: result with no item waiting, actual %h", actual);
        errors++;
      end else begin
        want = pending_masks.pop_front();
        if (actual !== want) begin
          $error("expired_mask mismatch: expected %h, actual %h", want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [mctt_pkg::OP_W-1:0]    operation_i = mctt_pkg::OP_TICK;
  logic [mctt_pkg::CH_W-1:0]    channel_i = '0;
  logic [mctt_pkg::LIMIT_W-1:0] limit_i = '0;
  logic                         notify_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [mctt_pkg::MASK_W-1:0]  expired_mask_o;

  expiry_tracker tracker = new;
  bit            steady;         // no random gaps on either side while set
  bit            long_hold_req;  // asks the receiver for a long hold-off

  multi_channel_tick_timer_bank DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .channel_i      (channel_i),
    .limit_i        (limit_i),
    .notify_i       (notify_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .expired_mask_o (expired_mask_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item, wait for acceptance, then idle for a random gap
  task automatic offer_item(logic [mctt_pkg::OP_W-1:0] op,
                            logic [mctt_pkg::CH_W-1:0] ch,
                            logic [mctt_pkg::LIMIT_W-1:0] lim, logic ntf);
    int gap;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    channel_i   <= ch;
    limit_i     <= lim;
    notify_i    <= ntf;
    do @(posedge clk_i); while (!in_ready_o);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every result has come back; the queue is
  // checked between edges so the monitor has already run for the last edge
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (tracker.pending_masks.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // One random item; starts mostly use small limits so channels expire
  task automatic random_item(output logic [mctt_pkg::OP_W-1:0] op,
                             output logic [mctt_pkg::CH_W-1:0] ch,
                             output logic [mctt_pkg::LIMIT_W-1:0] lim,
                             output logic ntf);
    int r;
    int s;
    r   = $urandom_range(0, 99);
    ch  = mctt_pkg::CH_W'($urandom_range(0, mctt_pkg::CHANNELS - 1));
    ntf = 1'($urandom_range(0, 1));
    lim = $urandom();
    if (r < 55) op = mctt_pkg::OP_TICK;
    else if (r < 77) op = mctt_pkg::OP_START;
    else if (r < 93) op = mctt_pkg::OP_STOP;
    else op = OP_UNUSED;
    if (op == mctt_pkg::OP_START) begin
      s = $urandom_range(0, 99);
      if (s < 70) lim = $urandom_range(0, 12);
      else if (s < 85) lim = $urandom_range(13, 60);
      else if (s < 97) lim = $urandom();
      else lim = ($urandom_range(0, 1) != 0) ? '1 : '0;
    end
  endtask

  // Receiver: runs of ready with random stalls, plus a long hold on request
  initial begin
    int run;
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      run = $urandom_range(1, 20);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Monitor both handshakes at each edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) tracker.compare_mask(expired_mask_o);
      if (in_valid_i && in_ready_o)
        tracker.record_item(operation_i, channel_i, limit_i, notify_i);
    end
  end

  // Run limit
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus
  initial begin
    logic [mctt_pkg::OP_W-1:0]    op;
    logic [mctt_pkg::CH_W-1:0]    ch;
    logic [mctt_pkg::LIMIT_W-1:0] lim;
    logic                         ntf;
    int                           counted;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero limit, all-ones limit, edge channels, notify off,
    // expiry one tick after the limit is reached, ignored code, stop/restart
    offer_item(mctt_pkg::OP_START, 3'd0, 32'd0, 1'b1);
    offer_item(mctt_pkg::OP_TICK, 3'd5, 32'hFFFF_FFFF, 1'b1);
    offer_item(mctt_pkg::OP_TICK, 3'd0, 32'd0, 1'b0);
    offer_item(mctt_pkg::OP_START, 3'd7, 32'hFFFF_FFFF, 1'b1);
    offer_item(mctt_pkg::OP_START, 3'd3, 32'd1, 1'b0);
    offer_item(mctt_pkg::OP_START, 3'd1, 32'd1, 1'b1);
    offer_item(mctt_pkg::OP_TICK, 3'd0, 32'd0, 1'b0);
    offer_item(mctt_pkg::OP_TICK, 3'd0, 32'd0, 1'b0);
    offer_item(OP_UNUSED, 3'd7, 32'hFFFF_FFFF, 1'b1);
    offer_item(mctt_pkg::OP_TICK, 3'd7, 32'hA5A5_5A5A, 1'b1);
    offer_item(mctt_pkg::OP_STOP, 3'd0, 32'hFFFF_FFFF, 1'b1);
    offer_item(mctt_pkg::OP_TICK, 3'd0, 32'd0, 1'b0);
    offer_item(mctt_pkg::OP_STOP, 3'd1, 32'd0, 1'b0);
    offer_item(mctt_pkg::OP_START, 3'd2, 32'd2, 1'b1);
    offer_item(mctt_pkg::OP_TICK, 3'd0, 32'd0, 1'b0);
    offer_item(mctt_pkg::OP_TICK, 3'd0, 32'd0, 1'b0);
    offer_item(mctt_pkg::OP_TICK, 3'd0, 32'd0, 1'b0);
    offer_item(mctt_pkg::OP_STOP, 3'd7, 32'd0, 1'b0);
    offer_item(mctt_pkg::OP_STOP, 3'd5, 32'd0, 1'b0);
    offer_item(mctt_pkg::OP_START, 3'd1, 32'd0, 1'b1);
    offer_item(mctt_pkg::OP_START, 3'd6, 32'd0, 1'b0);
    offer_item(mctt_pkg::OP_TICK, 3'd0, 32'd0, 1'b0);
    offer_item(mctt_pkg::OP_TICK, 3'd0, 32'd0, 1'b0);
    wait_drained();

    // Random items; ignored codes do not count
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      steady = (counted >= 200 && counted < 260) || (counted >= 500 && counted < 560);
      if (counted == 500 && !long_hold_req) long_hold_req = 1'b1;
      random_item(op, ch, lim, ntf);
      offer_item(op, ch, lim, ntf);
      if (op != OP_UNUSED) counted++;
      if (counted == 350 && op != OP_UNUSED) wait_drained();
    end
    steady = 1'b0;

    // Drain and let the output register settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.pending_masks.size() != 0) begin
      $error("expired_mask: %0d results never arrived", tracker.pending_masks.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
